// ----- sv/wtsf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtsf_pkg
// Shared types, constants and helper functions of the whitespace tolerant
// substring finder.
// ----------------------------------------------------------------------------
package wtsf_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int NEEDLE_BYTES = 16;
    localparam int CELLS        = 16;
    localparam int CNT_W        = 20;
    localparam int LEN_W        = 5;
    localparam int IDX_W        = $clog2(NEEDLE_BYTES);
    localparam int NEEDLE_W     = NEEDLE_BYTES * 8;
    localparam int CFG_W        = 64;

    // One pending bit per tracker cell, then the single-byte match, then the total.
    localparam int PEND_W       = CELLS + 2;
    localparam int SEL_W        = $clog2(PEND_W);
    localparam int START_BIT    = CELLS;
    localparam int TOTAL_BIT    = CELLS + 1;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(MAX_PATTERN < NEEDLE_BYTES ?
                                                   MAX_PATTERN : NEEDLE_BYTES);

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        CFG_NEEDLE_LENGTH = 2'd0,
        CFG_NEEDLE_LOW    = 2'd1,
        CFG_NEEDLE_HIGH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic             live;
        logic             good;
        logic [LEN_W-1:0] pos;
        pos_t             start;
    } tracker_t;

    // Per-byte control broadcast to every cell of the chain.
    typedef struct packed {
        logic             advance;
        logic             flush;
        logic [7:0]       text_byte;
        logic             is_ws;
        logic [LEN_W-1:0] len;
    } step_ctx_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] needle_byte(input logic [NEEDLE_W-1:0] needle,
                                               input logic [IDX_W-1:0]    idx);
        return needle[idx * 8 +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- sv/wtsf_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtsf_cell
// One tracker of the chain. It advances on each accepted byte and either
// keeps its own state or takes the state handed down by its upper neighbor.
// ----------------------------------------------------------------------------
module wtsf_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire wtsf_pkg::step_ctx_t            ctx,
    input  wire logic [wtsf_pkg::NEEDLE_W-1:0]  needle,
    input  wire wtsf_pkg::tracker_t             upper,
    input  wire logic                           hole_in,
    output wtsf_pkg::tracker_t                  handoff,
    output logic                                hole_out,
    output logic                                hit,
    output wtsf_pkg::pos_t                      hit_pos,
    output logic                                live
);

    wtsf_pkg::tracker_t cell_reg;
    wtsf_pkg::tracker_t cell_next;
    wtsf_pkg::tracker_t upd;
    logic [7:0]         exp_byte;
    logic               done;

    always_comb begin
        upd      = cell_reg;
        exp_byte = wtsf_pkg::needle_byte(needle, cell_reg.pos[wtsf_pkg::IDX_W-1:0]);
        if (cell_reg.live && (cell_reg.pos < ctx.len)) begin
            if (ctx.text_byte == exp_byte) begin
                upd.pos = cell_reg.pos + 1'b1;
            end else if (!ctx.is_ws) begin
                upd.good = 1'b0;
                upd.pos  = cell_reg.pos + 1'b1;
            end
        end
        done         = cell_reg.live && (upd.pos >= ctx.len);
        handoff      = upd;
        handoff.live = cell_reg.live && !done;
    end

    assign hit      = done && upd.good;
    assign hit_pos  = cell_reg.start;
    assign live     = cell_reg.live;
    // A freed slot here or below pulls everything above down by one place.
    assign hole_out = hole_in || !handoff.live;

    always_comb begin
        if (ctx.flush) begin
            cell_next      = handoff;
            cell_next.live = 1'b0;
        end else if (hole_out) begin
            cell_next = upper;
        end else begin
            cell_next = handoff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.live <= 1'b0;
        end else if (ctx.advance) begin
            cell_reg <= cell_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wtsf_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtsf_out
// Result stage and output register. Holds one byte's results, keeps the running
// match count and sends results one per cycle unless stalled, oldest tracker first.
// ----------------------------------------------------------------------------
module wtsf_out (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic [wtsf_pkg::PEND_W-1:0]    load_pend,
    input  wire wtsf_pkg::pos_t                 load_pos [wtsf_pkg::PEND_W],
    output logic                                stage_ready,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [wtsf_pkg::CNT_W-1:0]          m_hit_row,
    output logic [wtsf_pkg::CNT_W-1:0]          m_hit_column,
    output logic [wtsf_pkg::CNT_W-1:0]          m_match_total,
    output logic                                m_is_total,
    output logic                                m_run_end
);

    logic [wtsf_pkg::PEND_W-1:0] pend_reg;
    logic [wtsf_pkg::PEND_W-1:0] pend_next;
    wtsf_pkg::pos_t              pos_reg [wtsf_pkg::PEND_W];
    logic [wtsf_pkg::CNT_W-1:0]  count_reg;
    logic [wtsf_pkg::CNT_W-1:0]  count_next;
    logic                        valid_reg;
    logic [wtsf_pkg::CNT_W-1:0]  row_reg;
    logic [wtsf_pkg::CNT_W-1:0]  col_reg;
    logic [wtsf_pkg::CNT_W-1:0]  total_reg;
    logic                        is_total_reg;
    logic                        run_end_reg;

    logic [wtsf_pkg::SEL_W-1:0]  sel;
    logic [wtsf_pkg::PEND_W-1:0] sel_mask;
    logic [wtsf_pkg::PEND_W-1:0] rest;
    logic                        out_free;
    logic                        drain;
    logic                        sel_total;
    logic                        last_left;

    // Lowest pending bit goes first.
    always_comb begin
        sel = '0;
        for (int i = wtsf_pkg::PEND_W - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = wtsf_pkg::SEL_W'(i);
            end
        end
    end

    assign sel_mask  = wtsf_pkg::PEND_W'(1) << sel;
    assign rest      = pend_reg & ~sel_mask;
    assign out_free  = !valid_reg || m_ready;
    assign drain     = out_free && (pend_reg != '0);
    assign sel_total = (sel == wtsf_pkg::SEL_W'(wtsf_pkg::TOTAL_BIT));
    assign last_left = (pend_reg != '0) && (rest == '0);
    assign count_next = sel_total ? count_reg : wtsf_pkg::sat_inc(count_reg);

    assign stage_ready = (pend_reg == '0) || (last_left && out_free);

    always_comb begin
        if (load) begin
            pend_next = load_pend;
        end else if (drain) begin
            pend_next = rest;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (drain) begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pos_reg <= load_pos;
        end
        if (drain) begin
            row_reg      <= pos_reg[sel].row;
            col_reg      <= pos_reg[sel].col;
            total_reg    <= count_next;
            is_total_reg <= sel_total;
            run_end_reg  <= (rest == '0);
        end
    end

    assign m_valid       = valid_reg;
    assign m_hit_row     = row_reg;
    assign m_hit_column  = col_reg;
    assign m_match_total = total_reg;
    assign m_is_total    = is_total_reg;
    assign m_run_end     = run_end_reg;

endmodule

`default_nettype wire

// ----- sv/whitespace_tolerant_substring_finder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// whitespace_tolerant_substring_finder
// Streams text bytes and reports every start of a configured needle of up to
// sixteen bytes, skipping stray spaces, tabs and newlines inside a match.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while each byte causes at most one
// result and the output is not stalled. A byte with more results (completed
// matches, plus the total on the final byte) holds the input while the result
// stage hands them to the single output register one per cycle unless stalled;
// the next byte is taken in the same cycle as the last result of the previous
// one. Sixteen tracker cells form a chain ordered by age, the oldest at cell 0.
// On each accepted byte every cell compares the byte against the needle byte
// it expects; a finished tracker frees its cell, and all cells above the lowest
// free one shift down by one place, so a new tracker always enters at the top
// of the chain. When all sixteen cells stay busy a new start is ignored.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data and
// must only change while the block is idle. There is no clearing pass after
// reset; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module whitespace_tolerant_substring_finder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [wtsf_pkg::CFG_W-1:0]     cfg_wr_data,
    // Text input channel.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_text_byte,
    input  wire logic                           s_final_byte,
    // Result channel.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [wtsf_pkg::CNT_W-1:0]          m_hit_row,
    output logic [wtsf_pkg::CNT_W-1:0]          m_hit_column,
    output logic [wtsf_pkg::CNT_W-1:0]          m_match_total,
    output logic                                m_is_total,
    output logic                                m_run_end
);

    // Configuration registers.
    logic [wtsf_pkg::LEN_W-1:0]     needle_length_reg;
    logic [wtsf_pkg::CFG_W-1:0]     needle_low_reg;
    logic [wtsf_pkg::CFG_W-1:0]     needle_high_reg;
    logic [wtsf_pkg::NEEDLE_W-1:0]  needle;
    logic [wtsf_pkg::LEN_W-1:0]     len_eff;

    // Text position counters.
    logic [wtsf_pkg::CNT_W-1:0]     row_reg;
    logic [wtsf_pkg::CNT_W-1:0]     row_next;
    logic [wtsf_pkg::CNT_W-1:0]     col_reg;
    logic [wtsf_pkg::CNT_W-1:0]     col_next;

    logic                           accept;
    logic                           starts;
    logic                           single;
    wtsf_pkg::step_ctx_t            ctx;
    wtsf_pkg::tracker_t             new_trk;

    // Chain wiring: handoff[CELLS] is the tracker entering at the top.
    wtsf_pkg::tracker_t             handoff [wtsf_pkg::CELLS+1];
    logic [wtsf_pkg::CELLS:0]       hole_chain;
    logic [wtsf_pkg::CELLS-1:0]     hit_vec;
    logic [wtsf_pkg::CELLS-1:0]     live_vec;
    wtsf_pkg::pos_t                 load_pos [wtsf_pkg::PEND_W];
    logic [wtsf_pkg::PEND_W-1:0]    load_pend;
    logic                           stage_ready;

    // ---------------------------------------------------------------------
    // Configuration. Register indexes beyond the list are ignored.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_length_reg <= wtsf_pkg::LEN_W'(1);
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wtsf_pkg::CFG_NEEDLE_LENGTH: begin
                    needle_length_reg <= cfg_wr_data[wtsf_pkg::LEN_W-1:0];
                end
                wtsf_pkg::CFG_NEEDLE_LOW: begin
                    needle_low_reg <= cfg_wr_data;
                end
                wtsf_pkg::CFG_NEEDLE_HIGH: begin
                    needle_high_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign needle = {needle_high_reg, needle_low_reg};

    // A length of zero behaves as one, anything above the cap as the cap.
    always_comb begin
        if (needle_length_reg == '0) begin
            len_eff = wtsf_pkg::LEN_W'(1);
        end else if (needle_length_reg > wtsf_pkg::LEN_CAP) begin
            len_eff = wtsf_pkg::LEN_CAP;
        end else begin
            len_eff = needle_length_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Byte handling. A request is taken whenever the result stage can hold
    // this byte's results.
    // ---------------------------------------------------------------------
    assign s_ready = stage_ready;
    assign accept  = s_valid && s_ready;

    assign ctx.advance   = accept;
    assign ctx.flush     = s_final_byte;
    assign ctx.text_byte = s_text_byte;
    assign ctx.is_ws     = (s_text_byte == wtsf_pkg::CHAR_SPACE) ||
                           (s_text_byte == wtsf_pkg::CHAR_TAB)   ||
                           (s_text_byte == wtsf_pkg::CHAR_NEWLINE);
    assign ctx.len       = len_eff;

    assign starts = (s_text_byte == needle[7:0]);
    assign single = (len_eff == wtsf_pkg::LEN_W'(1));

    // A new tracker has already consumed the needle's first byte. It only
    // lands in the chain when some cell frees up this cycle or was free.
    assign new_trk.live      = starts && !single;
    assign new_trk.good      = 1'b1;
    assign new_trk.pos       = wtsf_pkg::LEN_W'(1);
    assign new_trk.start.row = row_reg;
    assign new_trk.start.col = col_reg;
    assign handoff[wtsf_pkg::CELLS] = new_trk;
    assign hole_chain[0]     = 1'b0;

    for (genvar i = 0; i < wtsf_pkg::CELLS; i++) begin : g_cell
        wtsf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctx      (ctx),
            .needle   (needle),
            .upper    (handoff[i+1]),
            .hole_in  (hole_chain[i]),
            .handoff  (handoff[i]),
            .hole_out (hole_chain[i+1]),
            .hit      (hit_vec[i]),
            .hit_pos  (load_pos[i]),
            .live     (live_vec[i])
        );
    end

    // The single-byte match comes after the cells' matches, the total last.
    assign load_pos[wtsf_pkg::START_BIT].row = row_reg;
    assign load_pos[wtsf_pkg::START_BIT].col = col_reg;
    assign load_pos[wtsf_pkg::TOTAL_BIT]     = '0;
    assign load_pend = {s_final_byte, starts && single, hit_vec};

    // A newline moves to the next row unless it opens a match, in which
    // case it only advances the column like any other byte.
    always_comb begin
        row_next = row_reg;
        col_next = wtsf_pkg::sat_inc(col_reg);
        if (!starts && (s_text_byte == wtsf_pkg::CHAR_NEWLINE)) begin
            row_next = wtsf_pkg::sat_inc(row_reg);
            col_next = wtsf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= wtsf_pkg::CNT_W'(1);
            col_reg <= wtsf_pkg::CNT_W'(1);
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result stage and output register.
    // ---------------------------------------------------------------------
    wtsf_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .load_pend     (load_pend),
        .load_pos      (load_pos),
        .stage_ready   (stage_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_row     (m_hit_row),
        .m_hit_column  (m_hit_column),
        .m_match_total (m_match_total),
        .m_is_total    (m_is_total),
        .m_run_end     (m_run_end)
    );

`ifndef NO_ASSERTIONS
    // The final byte leaves no tracker behind.
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_byte |=> (live_vec == '0))
        else $error("trackers survived the final byte");

    // Trackers move only when a byte is taken.
    a_cells_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(live_vec))
        else $error("tracker chain changed without a byte");

    // A total result closes its byte and carries no position.
    a_total_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_total |-> m_run_end && (m_hit_row == '0) && (m_hit_column == '0))
        else $error("malformed total result");

    // Results of one byte follow each other without a gap.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_end |=> m_valid)
        else $error("gap inside one byte's results");
`endif

endmodule

`default_nettype wire
